/* rtl/core/fqs_pkg.sv */
package fqs_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int TYPE_W  = 3;
   localparam int DATA_W  = 32;
   localparam int STS_W   = 2;
   localparam int POS_W   = 5;

   typedef enum logic [TYPE_W-1:0] {
      REQ_PUSH   = 3'd0,
      REQ_POP    = 3'd1,
      REQ_SEARCH = 3'd2,
      REQ_DUMP   = 3'd3,
      REQ_CLEAR  = 3'd4
   } req_code_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      EMIT_PLAIN,
      EMIT_POP,
      EMIT_DUMP,
      EMIT_MATCH,
      EMIT_SUM
   } emit_kind_type;

   typedef struct packed {
      logic          load_key;
      logic          push;
      logic          pop;
      logic          clr;
      logic          walk_start;
      logic          walk_step;
      logic          rd_walk;
      logic          emit;
      emit_kind_type kind;
      status_type    sts;
      logic          last;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic out_free;
      logic hit;
      logic walk_end;
   } stat_type;

endpackage

/* rtl/core/fqs_if.sv */
interface fqs_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [fqs_pkg::TYPE_W-1:0]           req_type;
   logic signed [fqs_pkg::DATA_W-1:0]    data_value;

   modport source (output valid, output req_type, output data_value, input ready);
   modport sink   (input valid, input req_type, input data_value, output ready);
endinterface

interface fqs_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [fqs_pkg::STS_W-1:0]            status;
   logic signed [fqs_pkg::DATA_W-1:0]    item_value;
   logic [fqs_pkg::POS_W-1:0]            match_position;
   logic [fqs_pkg::POS_W-1:0]            earlier_matches;
   logic                                 found;
   logic                                 last;

   modport source (output valid, output status, output item_value, output match_position,
                   output earlier_matches, output found, output last, input ready);
   modport sink   (input valid, input status, input item_value, input match_position,
                   input earlier_matches, input found, input last, output ready);
endinterface

/* rtl/core/fqs_ctrl.sv */
module fqs_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [fqs_pkg::TYPE_W-1:0]  req_type,
   output logic                        req_ready,
   input  fqs_pkg::stat_type           stat,
   output fqs_pkg::cmd_type            cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_RD,
      ST_EVAL,
      ST_SUM
   } state_type;

   state_type state_ff, state_in;
   logic      is_search_ff, is_search_in;
   logic      acc;

   assign req_ready = (state_ff == ST_IDLE) && stat.out_free;
   assign acc       = req_valid && req_ready;

   always_comb begin
      cmd          = '0;
      cmd.kind     = fqs_pkg::EMIT_PLAIN;
      cmd.sts      = fqs_pkg::STS_OK;
      state_in     = state_ff;
      is_search_in = is_search_ff;
      cmd.load_key = acc;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               case (req_type)
                  fqs_pkg::REQ_PUSH: begin
                     cmd.emit = 1'b1;
                     cmd.last = 1'b1;
                     if (stat.full) begin
                        cmd.sts = fqs_pkg::STS_FULL;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end
                  fqs_pkg::REQ_POP: begin
                     if (stat.empty) begin
                        cmd.emit = 1'b1;
                        cmd.last = 1'b1;
                        cmd.sts  = fqs_pkg::STS_EMPTY;
                     end else begin
                        state_in = ST_POP;
                     end
                  end
                  fqs_pkg::REQ_SEARCH, fqs_pkg::REQ_DUMP: begin
                     if (stat.empty) begin
                        cmd.emit = 1'b1;
                        cmd.last = 1'b1;
                        cmd.sts  = fqs_pkg::STS_EMPTY;
                     end else begin
                        cmd.walk_start = 1'b1;
                        is_search_in   = (req_type == fqs_pkg::REQ_SEARCH);
                        state_in       = ST_RD;
                     end
                  end
                  fqs_pkg::REQ_CLEAR: begin
                     cmd.emit = 1'b1;
                     cmd.last = 1'b1;
                     cmd.clr  = 1'b1;
                     cmd.sts  = stat.empty ? fqs_pkg::STS_EMPTY : fqs_pkg::STS_OK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = fqs_pkg::EMIT_POP;
               cmd.last = 1'b1;
               cmd.pop  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RD: begin
            cmd.rd_walk = 1'b1;
            state_in    = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.rd_walk = 1'b1;
            if (stat.out_free) begin
               cmd.walk_step = 1'b1;
               if (is_search_ff) begin
                  cmd.emit = stat.hit;
                  cmd.kind = fqs_pkg::EMIT_MATCH;
                  state_in = stat.walk_end ? ST_SUM : ST_RD;
               end else begin
                  cmd.emit = 1'b1;
                  cmd.kind = fqs_pkg::EMIT_DUMP;
                  cmd.last = stat.walk_end;
                  state_in = stat.walk_end ? ST_IDLE : ST_RD;
               end
            end
         end
         ST_SUM: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = fqs_pkg::EMIT_SUM;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         is_search_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         is_search_ff <= is_search_in;
      end
   end

endmodule

/* rtl/core/fqs_datapath.sv */
module fqs_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [fqs_pkg::DATA_W-1:0] data_value,
   input  fqs_pkg::cmd_type                  cmd,
   output fqs_pkg::stat_type                 stat,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [fqs_pkg::STS_W-1:0]         rsp_status,
   output logic signed [fqs_pkg::DATA_W-1:0] rsp_item_value,
   output logic [fqs_pkg::POS_W-1:0]         rsp_match_position,
   output logic [fqs_pkg::POS_W-1:0]         rsp_earlier_matches,
   output logic                              rsp_found,
   output logic                              rsp_last
);

   localparam int IW = fqs_pkg::IDX_W;
   localparam int CW = fqs_pkg::CNT_W;
   localparam int DW = fqs_pkg::DATA_W;
   localparam int PW = fqs_pkg::POS_W;

   // ring index: base + offset, wrapped once (the sum stays below twice the depth)
   function automatic logic [IW-1:0] slot_idx(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(off);
      if (s >= (CW+1)'(fqs_pkg::DEPTH)) begin
         s = s - (CW+1)'(fqs_pkg::DEPTH);
      end
      return IW'(s);
   endfunction

   logic signed [DW-1:0] mem [fqs_pkg::DEPTH];
   logic signed [DW-1:0] rd_ff;
   logic signed [DW-1:0] key_ff;
   logic [IW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        ofs_ff, ofs_in;
   logic [CW-1:0]        matches_ff, matches_in;
   logic [IW-1:0]        rd_addr;
   logic                 out_valid_ff;
   logic                 out_free;

   assign out_free = !out_valid_ff || rsp_ready;
   assign rd_addr  = cmd.rd_walk ? slot_idx(head_ff, ofs_ff) : head_ff;

   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == CW'(fqs_pkg::DEPTH));
   assign stat.out_free = out_free;
   assign stat.hit      = (rd_ff == key_ff);
   assign stat.walk_end = ((ofs_ff + CW'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[slot_idx(head_ff, count_ff)] <= data_value;
      end
      rd_ff <= mem[rd_addr];
      if (cmd.load_key) begin
         key_ff <= data_value;
      end
   end

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      ofs_in     = ofs_ff;
      matches_in = matches_ff;
      if (cmd.push) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.pop) begin
         head_in  = slot_idx(head_ff, CW'(1));
         count_in = count_ff - CW'(1);
      end
      if (cmd.clr) begin
         head_in  = '0;
         count_in = '0;
      end
      if (cmd.walk_start) begin
         ofs_in     = '0;
         matches_in = '0;
      end
      if (cmd.walk_step) begin
         ofs_in = ofs_ff + CW'(1);
         if (stat.hit) begin
            matches_in = matches_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         ofs_ff       <= '0;
         matches_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff    <= head_in;
         count_ff   <= count_in;
         ofs_ff     <= ofs_in;
         matches_ff <= matches_in;
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status          <= cmd.sts;
         rsp_last            <= cmd.last;
         rsp_item_value      <= '0;
         rsp_match_position  <= '0;
         rsp_earlier_matches <= '0;
         rsp_found           <= 1'b0;
         case (cmd.kind)
            fqs_pkg::EMIT_POP, fqs_pkg::EMIT_DUMP: begin
               rsp_item_value <= rd_ff;
            end
            fqs_pkg::EMIT_MATCH: begin
               rsp_match_position  <= PW'(ofs_ff + CW'(1));
               rsp_earlier_matches <= PW'(matches_ff);
            end
            fqs_pkg::EMIT_SUM: begin
               rsp_earlier_matches <= PW'(matches_ff);
               rsp_found           <= (matches_ff != '0);
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

/* rtl/core/fifo_queue_with_search_unit.sv */
// Push and clear: result in the output register in the cycle after acceptance. Unused codes
// are dropped on acceptance and give no result. Pop: registered store read, then result.
// Search and dump: per stored entry a registered read, then compare/emit; search adds a
// summary step; a blocked output register stalls the pop, compare/emit and summary steps.
// Throughput: one push or clear per cycle while results are taken; the store read port sets
// the walk rate. Reset is synchronous, active high: it empties the queue, zeroes the head
// and drops any pending result; store contents are left as they are.
module fifo_queue_with_search_unit (
   input  logic      clock,
   input  logic      reset,
   fqs_req_if.sink   req_ch,
   fqs_rsp_if.source rsp_ch
);

   fqs_pkg::cmd_type  cmd;
   fqs_pkg::stat_type stat;

   // Controller: decodes each request transaction, sequences pop reads and the
   // entry walk used by search and dump, and holds off new transactions while
   // a pop or walk is running or the output register cannot take another result.
   fqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: ring store with head and count, walk offset and match counter,
   // search key, and the output register that parts the result side from the
   // request side, so a new transaction can be taken in the cycle the waiting
   // result leaves.
   fqs_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .data_value          (req_ch.data_value),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_ready           (rsp_ch.ready),
      .rsp_valid           (rsp_ch.valid),
      .rsp_status          (rsp_ch.status),
      .rsp_item_value      (rsp_ch.item_value),
      .rsp_match_position  (rsp_ch.match_position),
      .rsp_earlier_matches (rsp_ch.earlier_matches),
      .rsp_found           (rsp_ch.found),
      .rsp_last            (rsp_ch.last)
   );

endmodule

/* rtl/core/fqs_checker.sv */
module fqs_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [fqs_pkg::STS_W-1:0]  rsp_status,
   input logic [fqs_pkg::POS_W-1:0]  rsp_match_position,
   input logic [fqs_pkg::POS_W-1:0]  rsp_earlier_matches,
   input logic                       rsp_found,
   input logic                       rsp_last
);

   // hold a result until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // no result straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a request is only taken when the output register has room
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("request taken with output register blocked");

   // a found summary closes the search and carries no position
   a_found_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_last && (rsp_match_position == '0) &&
                                 (rsp_earlier_matches != '0) &&
                                 (rsp_status == fqs_pkg::STS_OK))
      else $error("malformed search summary");

endmodule

bind fifo_queue_with_search_unit fqs_checker u_fqs_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_status          (rsp_ch.status),
   .rsp_match_position  (rsp_ch.match_position),
   .rsp_earlier_matches (rsp_ch.earlier_matches),
   .rsp_found           (rsp_ch.found),
   .rsp_last            (rsp_ch.last)
);

/* sim/fifo_queue_with_search_unit_tb.sv */
module fifo_queue_with_search_unit_tb;

   localparam int TYPE_W = fqs_pkg::TYPE_W;
   localparam int DATA_W = fqs_pkg::DATA_W;
   localparam int POS_W  = fqs_pkg::POS_W;
   localparam int DEPTH  = fqs_pkg::DEPTH;

   // Request codes beyond clear are spare: the block must swallow them silently.
   localparam logic [TYPE_W-1:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_SPARE_LAST  = 3'd7;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int STALL_CYCLES  = 80;
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_ITEMS  = 95;

   typedef struct {
      logic [TYPE_W-1:0]        code;
      logic signed [DATA_W-1:0] value;
   } queue_request_type;

   typedef struct {
      fqs_pkg::status_type      status;
      logic signed [DATA_W-1:0] item_value;
      logic [POS_W-1:0]         position;
      logic [POS_W-1:0]         earlier;
      logic                     found;
      logic                     last;
   } queue_result_type;

   logic clock;
   logic reset;

   fqs_req_if req_ch ();
   fqs_rsp_if rsp_ch ();

   fifo_queue_with_search_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Transactions waiting to be offered, and results the queue owes us.
   queue_request_type request_backlog[$];
   queue_result_type  awaited_results[$];

   // Mirror of the queue contents, updated as each request transaction is accepted.
   logic signed [DATA_W-1:0] mirror_entries [DEPTH];
   int unsigned              mirror_head;
   int unsigned              mirror_count;

   // A small pool of values so that searches find repeated entries.
   logic signed [DATA_W-1:0] value_pool [8] = '{
      32'sd0, -32'sd1, 32'sd1, 32'sd42,
      32'sh8000_0000, 32'sh7fff_ffff, 32'sh5555_5555, -32'sd7
   };

   int  snd_idle_pct;
   int  rsp_idle_pct;
   int  fail_count;
   int  cycle_count;
   logic req_taken;
   logic stall_wanted;
   logic stall_active;
   queue_request_type next_request;
   queue_result_type  oldest_result;

   // Clock, plus known values on every input from time zero.
   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.req_type  = fqs_pkg::REQ_PUSH;
      req_ch.data_value = '0;
      rsp_ch.ready     = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   function automatic void owe_result(input fqs_pkg::status_type st,
                                      input logic signed [DATA_W-1:0] val,
                                      input logic [POS_W-1:0] pos,
                                      input logic [POS_W-1:0] earlier,
                                      input logic fnd,
                                      input logic lst);
      queue_result_type r;
      r.status     = st;
      r.item_value = val;
      r.position   = pos;
      r.earlier    = earlier;
      r.found      = fnd;
      r.last       = lst;
      awaited_results.push_back(r);
   endfunction

   // Work out the results of one accepted request and advance the mirror.
   function automatic void mirror_request(input logic [TYPE_W-1:0] code,
                                          input logic signed [DATA_W-1:0] value);
      int unsigned hits;
      int unsigned slot;
      hits = 0;
      case (code)
         fqs_pkg::REQ_PUSH: begin
            if (mirror_count >= DEPTH) begin
               owe_result(fqs_pkg::STS_FULL, '0, '0, '0, 1'b0, 1'b1);
            end else begin
               mirror_entries[(mirror_head + mirror_count) % DEPTH] = value;
               mirror_count++;
               owe_result(fqs_pkg::STS_OK, '0, '0, '0, 1'b0, 1'b1);
            end
         end
         fqs_pkg::REQ_POP: begin
            if (mirror_count == 0) begin
               owe_result(fqs_pkg::STS_EMPTY, '0, '0, '0, 1'b0, 1'b1);
            end else begin
               owe_result(fqs_pkg::STS_OK, mirror_entries[mirror_head], '0, '0, 1'b0, 1'b1);
               mirror_head  = (mirror_head + 1) % DEPTH;
               mirror_count--;
            end
         end
         fqs_pkg::REQ_SEARCH: begin
            if (mirror_count == 0) begin
               owe_result(fqs_pkg::STS_EMPTY, '0, '0, '0, 1'b0, 1'b1);
            end else begin
               for (int unsigned i = 0; i < mirror_count; i++) begin
                  slot = (mirror_head + i) % DEPTH;
                  if (mirror_entries[slot] == value) begin
                     owe_result(fqs_pkg::STS_OK, '0, POS_W'(i + 1), POS_W'(hits), 1'b0, 1'b0);
                     hits++;
                  end
               end
               owe_result(fqs_pkg::STS_OK, '0, '0, POS_W'(hits), hits != 0, 1'b1);
            end
         end
         fqs_pkg::REQ_DUMP: begin
            if (mirror_count == 0) begin
               owe_result(fqs_pkg::STS_EMPTY, '0, '0, '0, 1'b0, 1'b1);
            end else begin
               for (int unsigned i = 0; i < mirror_count; i++)
                  owe_result(fqs_pkg::STS_OK, mirror_entries[(mirror_head + i) % DEPTH],
                             '0, '0, 1'b0, i + 1 == mirror_count);
            end
         end
         fqs_pkg::REQ_CLEAR: begin
            owe_result(mirror_count == 0 ? fqs_pkg::STS_EMPTY : fqs_pkg::STS_OK,
                       '0, '0, '0, 1'b0, 1'b1);
            mirror_head  = 0;
            mirror_count = 0;
         end
         default: ;  // spare codes: no result, no change
      endcase
   endfunction

   // Driver: present a new transaction at the falling edge once the last one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (request_backlog.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
            next_request       = request_backlog.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.req_type   <= next_request.code;
            req_ch.data_value <= next_request.value;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Acceptance: predict on every request transaction as it is taken.
   always @(posedge clock) begin
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready)
         mirror_request(req_ch.req_type, req_ch.data_value);
   end

   // Receiver: random back-pressure, or a hard hold while the long stall runs.
   always @(negedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= !stall_active && ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Monitor: compare each result transaction with the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_results.size() == 0) begin
            log_failure($sformatf({"unexpected result: sts=%0d val=%0d pos=%0d ear=%0d",
                                   " fnd=%0b last=%0b"},
                                  rsp_ch.status, rsp_ch.item_value, rsp_ch.match_position,
                                  rsp_ch.earlier_matches, rsp_ch.found, rsp_ch.last));
         end else begin
            oldest_result = awaited_results.pop_front();
            if (rsp_ch.status !== oldest_result.status ||
                rsp_ch.item_value !== oldest_result.item_value ||
                rsp_ch.match_position !== oldest_result.position ||
                rsp_ch.earlier_matches !== oldest_result.earlier ||
                rsp_ch.found !== oldest_result.found ||
                rsp_ch.last !== oldest_result.last)
               log_failure($sformatf({"mismatch: exp sts=%0d val=%0d pos=%0d ear=%0d fnd=%0b",
                                      " last=%0b / got sts=%0d val=%0d pos=%0d ear=%0d fnd=%0b",
                                      " last=%0b"},
                                     oldest_result.status, oldest_result.item_value,
                                     oldest_result.position, oldest_result.earlier,
                                     oldest_result.found, oldest_result.last,
                                     rsp_ch.status, rsp_ch.item_value, rsp_ch.match_position,
                                     rsp_ch.earlier_matches, rsp_ch.found, rsp_ch.last));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Long receiver hold, counted here so the sender keeps offering meanwhile.
   initial begin
      stall_active = 1'b0;
      wait (stall_wanted);
      @(posedge clock);
      stall_active = 1'b1;
      repeat (STALL_CYCLES) @(posedge clock);
      stall_active = 1'b0;
   end

   task automatic add_request(input logic [TYPE_W-1:0] code,
                              input logic signed [DATA_W-1:0] value);
      queue_request_type r;
      r.code  = code;
      r.value = value;
      request_backlog.push_back(r);
   endtask

   // Hold until everything offered is taken and every result owed has arrived.
   task automatic wait_drained();
      do @(posedge clock);
      while (request_backlog.size() != 0 || req_ch.valid || awaited_results.size() != 0);
   endtask

   // Random mix, weighted towards push so the queue regularly fills and wraps.
   task automatic queue_random(input int wanted);
      int                       taken;
      int                       pick;
      logic [TYPE_W-1:0]        code;
      logic signed [DATA_W-1:0] value;
      taken = 0;
      while (taken < wanted) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)      code = fqs_pkg::REQ_PUSH;
         else if (pick < 64) code = fqs_pkg::REQ_POP;
         else if (pick < 77) code = fqs_pkg::REQ_SEARCH;
         else if (pick < 87) code = fqs_pkg::REQ_DUMP;
         else if (pick < 91) code = fqs_pkg::REQ_CLEAR;
         else                code = TYPE_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
         if ($urandom_range(0, 99) < 65) value = value_pool[$urandom_range(0, 7)];
         else                            value = $urandom;
         add_request(code, value);
         if (code <= fqs_pkg::REQ_CLEAR) taken++;
      end
   endtask

   initial begin
      fail_count   = 0;
      cycle_count  = 0;
      req_taken    = 1'b0;
      stall_wanted = 1'b0;
      mirror_head  = 0;
      mirror_count = 0;
      snd_idle_pct = 11;
      rsp_idle_pct = 75;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every request on an empty queue, spare codes, extreme values.
      add_request(fqs_pkg::REQ_POP, '0);
      add_request(fqs_pkg::REQ_SEARCH, 32'sd42);
      add_request(fqs_pkg::REQ_DUMP, '0);
      add_request(fqs_pkg::REQ_CLEAR, '0);
      add_request(REQ_SPARE_FIRST, 32'sh7fff_ffff);
      add_request(REQ_SPARE_FIRST + 3'd1, '0);
      add_request(REQ_SPARE_LAST, 32'sh8000_0000);
      add_request(fqs_pkg::REQ_PUSH, 32'sh8000_0000);
      add_request(fqs_pkg::REQ_PUSH, 32'sh7fff_ffff);
      add_request(fqs_pkg::REQ_PUSH, 32'sd0);
      add_request(fqs_pkg::REQ_PUSH, -32'sd1);
      add_request(fqs_pkg::REQ_PUSH, 32'sh8000_0000);
      add_request(fqs_pkg::REQ_PUSH, 32'sd5);
      add_request(fqs_pkg::REQ_SEARCH, 32'sh8000_0000);
      add_request(fqs_pkg::REQ_SEARCH, 32'sd12345);
      add_request(fqs_pkg::REQ_DUMP, '0);
      add_request(fqs_pkg::REQ_POP, '0);
      add_request(fqs_pkg::REQ_CLEAR, '0);
      add_request(fqs_pkg::REQ_PUSH, 32'sd7);
      add_request(fqs_pkg::REQ_POP, '0);
      add_request(fqs_pkg::REQ_POP, '0);
      wait_drained();

      queue_random(RANDOM_ITEMS);
      wait_drained();

      // Pressure: hold the receiver while pushes keep coming, so the queue fills,
      // overflows and the input channel backs up.
      snd_idle_pct = 0;
      rsp_idle_pct = 0;
      stall_wanted = 1'b1;
      add_request(fqs_pkg::REQ_CLEAR, '0);
      for (int i = 0; i < 20; i++) add_request(fqs_pkg::REQ_PUSH, 32'sd42);
      wait_drained();
      // Full queue: sixteen matches, then wrap the head and search again.
      add_request(fqs_pkg::REQ_DUMP, '0);
      add_request(fqs_pkg::REQ_SEARCH, 32'sd42);
      add_request(fqs_pkg::REQ_POP, '0);
      add_request(fqs_pkg::REQ_POP, '0);
      add_request(fqs_pkg::REQ_PUSH, 32'sd9);
      add_request(fqs_pkg::REQ_PUSH, 32'sd42);
      add_request(fqs_pkg::REQ_SEARCH, 32'sd42);
      add_request(fqs_pkg::REQ_SEARCH, 32'sd9);
      add_request(fqs_pkg::REQ_DUMP, '0);
      wait_drained();

      snd_idle_pct = 75;
      rsp_idle_pct = 11;
      queue_random(RANDOM_ITEMS);
      wait_drained();

      snd_idle_pct = 0;
      rsp_idle_pct = 0;
      queue_random(RANDOM_ITEMS);
      wait_drained();

      // Allow any stray trailing result to show up before judging.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0)
         log_failure($sformatf("%0d results never arrived", awaited_results.size()));

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
